// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

// ----- rtl/core/mhpq_pkg.sv -----
// Package: types, constants and codes of the max-heap priority queue.
package mhpq_pkg;
    localparam int CAPACITY = 512;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_REPLACE = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [15:0] rain;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } state_t;
endpackage

// ----- rtl/core/mhpq_ram.sv -----
// Synchronous RAM with one write port and two read ports holding the heap records.
module mhpq_ram
    import mhpq_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  rec_t          wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output rec_t          rdata_a,
    output rec_t          rdata_b
);
    rec_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ----- rtl/core/max_heap_priority_queue.sv -----
// Top level: binary max-heap priority queue of precipitation records.
// One operation is taken per transfer and one result transfer follows. Insert
// scans all held entries through the RAM read port (one per cycle) and then
// sifts up, reading the parent in S_UP_RD and comparing it in S_UP_CMP at each
// level; remove and replace sift down through S_DN_RD2 and S_DN_CMP at each
// level; clear empties the heap. The heap lives in one two-read, one-write RAM.
`include "assert_macros.svh"
module max_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // operation
    input  logic [39:0] s_tdata,   // rec_day, rec_month, rec_year, rec_rain, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // status
    output logic [47:0] m_tdata    // top_day, top_month, top_year, top_rain, held_count, pad
);
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    op_reg, op_next;
    rec_t          rec_reg, rec_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    status_reg, status_next;
    rec_t          top_reg, top_next;
    logic          out_valid_reg, out_valid_next;

    logic          we;
    logic [AW-1:0] waddr, ra, rb;
    rec_t          wdata, rda, rdb;
    rec_t          in_rec;
    logic [CW:0]   lc, rc;

    assign in_rec = rec_t'({s_tdata[36:21], s_tdata[20:9], s_tdata[8:5], s_tdata[4:0]});
    assign lc = {1'b0, pos_reg, 1'b1} - (CW+1)'(0);
    assign rc = {1'b0, pos_reg, 1'b0} + (CW+1)'(2);

    mhpq_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        rec_reg    <= rec_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        top_reg    <= top_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        rec_next       = rec_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        we    = 1'b0;
        waddr = pos_reg;
        wdata = rec_reg;
        ra    = idx_reg[AW-1:0];
        rb    = idx_reg[AW-1:0];
        s_tready = (state_reg == S_IDLE) && !out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    op_next     = s_tuser;
                    rec_next    = in_rec;
                    status_next = ST_OK;
                    idx_next    = '0;
                    pos_next    = '0;
                    unique case (s_tuser)
                        OP_INSERT:
                        begin
                            ra = '0;
                            state_next = S_SCAN;
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_TOP_RD;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                ra = AW'(count_reg - CW'(1));
                                state_next = S_DN_RD;
                            end
                        end
                        OP_REPLACE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            state_next = (count_reg == '0) ? S_TOP_RD : S_DN_RD2;
                        end
                        default:
                        begin
                            count_next = '0;
                            state_next = S_TOP_RD;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // rda holds entry idx_reg
                if (idx_reg < count_reg && rda.day == rec_reg.day &&
                    rda.month == rec_reg.month && rda.year == rec_reg.year)
                begin
                    status_next = ST_DUP;
                    state_next  = S_TOP_RD;
                end
                else if (idx_reg >= count_reg)
                begin
                    if (count_reg == CW'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_TOP_RD;
                    end
                    else
                    begin
                        pos_next   = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                        state_next = S_UP_RD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    ra = AW'(idx_reg + CW'(1));
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we = 1'b1;
                    state_next = S_TOP_RD;
                end
                else
                begin
                    ra = (pos_reg - AW'(1)) >> 1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (rec_reg.rain > rda.rain)
                begin
                    we = 1'b1;
                    wdata = rda;
                    pos_next = (pos_reg - AW'(1)) >> 1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    we = 1'b1;
                    state_next = S_TOP_RD;
                end
            end
            S_DN_RD:
            begin
                // last entry arrives for remove
                rec_next = rda;
                state_next = S_DN_RD2;
            end
            S_DN_RD2:
            begin
                ra = lc[AW-1:0];
                rb = rc[AW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_TOP_RD;
                end
                else if (lc < {1'b0, count_reg} && rda.rain > rec_reg.rain &&
                         !(rc < {1'b0, count_reg} && rdb.rain > rda.rain))
                begin
                    we = 1'b1;
                    wdata = rda;
                    pos_next = lc[AW-1:0];
                    state_next = S_DN_RD2;
                end
                else if (rc < {1'b0, count_reg} && rdb.rain > rec_reg.rain)
                begin
                    we = 1'b1;
                    wdata = rdb;
                    pos_next = rc[AW-1:0];
                    state_next = S_DN_RD2;
                end
                else
                begin
                    we = 1'b1;
                    state_next = S_TOP_RD;
                end
            end
            S_TOP_RD:
            begin
                ra = '0;
                state_next = S_TOP_WAIT;
            end
            S_TOP_WAIT:
            begin
                top_next = (count_reg == '0) ? '0 : rda;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, 10'(count_reg), top_reg.rain, top_reg.year,
                       top_reg.month, top_reg.day};

    `ASSERT_IMPL(a_cnt_cap, clk, rst_n, 1'b1 |-> count_reg <= CW'(CAPACITY), "count over capacity")
    `ASSERT_IMPL(a_rdy_out, clk, rst_n, out_valid_reg |-> !s_tready, "input taken while result waits")
    `ASSERT_IMPL(a_hold, clk, rst_n, (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata), "result dropped")
endmodule

// ----- verif/mhpq_checker.sv -----
// Checker: watches both channels of the heap queue, predicts each result and compares.
`timescale 1ns / 100ps
module mhpq_checker
    import mhpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [1:0]  m_tuser,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  held;
        logic [15:0] rain;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } outcome_t;

    rec_t     heap_model [CAPACITY];
    int       held_model;
    outcome_t outcome_q [$];

    task automatic swap_slots(input int a, input int b);
        rec_t t;
        t = heap_model[a];
        heap_model[a] = heap_model[b];
        heap_model[b] = t;
    endtask

    task automatic sink_root();
        int p;
        int best;
        p = 0;
        while (p < held_model) begin
            best = p;
            if (2*p+1 < held_model && heap_model[2*p+1].rain > heap_model[best].rain)
                best = 2*p+1;
            if (2*p+2 < held_model && heap_model[2*p+2].rain > heap_model[best].rain)
                best = 2*p+2;
            if (best == p)
                break;
            swap_slots(p, best);
            p = best;
        end
    endtask

    function automatic logic date_present(rec_t r);
        for (int k = 0; k < held_model; k++)
            if (heap_model[k].day == r.day && heap_model[k].month == r.month &&
                heap_model[k].year == r.year)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic apply_op(input logic [1:0] op, input rec_t r);
        outcome_t o;
        int p;
        o = '0;
        o.status = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (date_present(r))
                    o.status = ST_DUP;
                else if (held_model >= CAPACITY)
                    o.status = ST_FULL;
                else
                begin
                    heap_model[held_model] = r;
                    p = held_model;
                    held_model++;
                    while (p > 0 && heap_model[p].rain > heap_model[(p-1)/2].rain)
                    begin
                        swap_slots(p, (p-1)/2);
                        p = (p-1)/2;
                    end
                end
            end
            OP_REMOVE, OP_REPLACE:
            begin
                if (held_model == 0)
                    o.status = ST_EMPTY;
                else if (op == OP_REMOVE)
                begin
                    held_model--;
                    heap_model[0] = heap_model[held_model];
                    sink_root();
                end
                else
                begin
                    heap_model[0] = r;
                    sink_root();
                end
            end
            default: held_model = 0;
        endcase
        if (held_model > 0)
        begin
            o.day   = heap_model[0].day;
            o.month = heap_model[0].month;
            o.year  = heap_model[0].year;
            o.rain  = heap_model[0].rain;
        end
        o.held = held_model[9:0];
        outcome_q.push_back(o);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        outcome_t a;
        if (!rst_n)
        begin
            held_model   <= 0;
            fail_count   <= 0;
            result_count <= 0;
            pending      <= 0;
            outcome_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_op(s_tuser, s_tdata[36:0]);
            if (m_tvalid && m_tready)
            begin
                result_count <= result_count + 1;
                a.status = m_tuser;
                a.day    = m_tdata[4:0];
                a.month  = m_tdata[8:5];
                a.year   = m_tdata[20:9];
                a.rain   = m_tdata[36:21];
                a.held   = m_tdata[46:37];
                if (outcome_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transfer: %p", a);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = outcome_q.pop_front();
                    if (a !== e)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", e, a);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= outcome_q.size();
        end
    end
endmodule

// ----- verif/max_heap_priority_queue_tb.sv -----
// Testbench top: drives heap queue operations with random stalls and gives the verdict.
`timescale 1ns / 100ps
module max_heap_priority_queue_tb;
    import mhpq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [47:0] m_tdata;
    int          fail_count;
    int          pending;
    int          result_count;
    int          send_idle;
    int          recv_idle;
    int          idle_cycles;
    int          ops_sent;
    int          depth_peak;
    int          held_est;

    max_heap_priority_queue dut (.*);
    mhpq_checker checker_i (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("watchdog expired");
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_op(input logic [1:0] op, input logic [4:0] d, input logic [3:0] m,
                           input logic [11:0] y, input logic [15:0] r);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, r, y, m, d};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ops_sent++;
        case (op)
            OP_INSERT: held_est = (held_est < CAPACITY) ? held_est + 1 : held_est;
            OP_REMOVE: held_est = (held_est > 0) ? held_est - 1 : 0;
            OP_CLEAR:  held_est = 0;
            default: ;
        endcase
        if (held_est > depth_peak)
            depth_peak = held_est;
    endtask

    // unique dates: day/month from index, year from index high bits
    task automatic fill_unique(input int n, input int base);
        for (int i = 0; i < n; i++)
            send_op(OP_INSERT, 5'((base + i) % 32), 4'(((base + i) / 32) % 16),
                    12'(((base + i) / 512) + 12'd2000), 16'($urandom));
    endtask

    task automatic random_phase(input int n);
        logic [1:0] op;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            op = (pick < 55) ? OP_INSERT : (pick < 80) ? OP_REMOVE :
                 (pick < 97) ? OP_REPLACE : OP_CLEAR;
            // narrow dates so duplicates show up
            send_op(op, 5'($urandom_range(3)), 4'($urandom_range(2)),
                    ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(3)),
                    ($urandom_range(4) == 0) ? 16'($urandom_range(3)) : 16'($urandom));
        end
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tuser = OP_INSERT;
        s_tdata = '0;
        m_tready = 1'b0;
        idle_cycles = 0;
        ops_sent = 0;
        depth_peak = 0;
        held_est = 0;
        send_idle = 19;
        recv_idle = 63;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-heap cases, extremes, ties, duplicates
        send_op(OP_REMOVE, 5'd1, 4'd1, 12'd0, 16'd0);
        send_op(OP_REPLACE, 5'd31, 4'd12, 12'd4095, 16'hFFFF);
        send_op(OP_INSERT, 5'd31, 4'd15, 12'd4095, 16'hFFFF);
        send_op(OP_INSERT, 5'd0, 4'd0, 12'd0, 16'd0);
        send_op(OP_INSERT, 5'd31, 4'd15, 12'd4095, 16'd5);
        send_op(OP_INSERT, 5'd1, 4'd1, 12'd1, 16'hFFFF);
        send_op(OP_INSERT, 5'd2, 4'd1, 12'd1, 16'hFFFF);
        send_op(OP_INSERT, 5'd10, 4'd6, 12'd2048, 16'h8000);
        send_op(OP_REPLACE, 5'd31, 4'd15, 12'd4095, 16'd0);
        send_op(OP_REPLACE, 5'd21, 4'd10, 12'd1365, 16'h5555);
        send_op(OP_REMOVE, 5'd0, 4'd0, 12'd0, 16'd0);
        send_op(OP_REMOVE, 5'd0, 4'd0, 12'd0, 16'd0);
        send_op(OP_CLEAR, 5'd31, 4'd15, 12'd4095, 16'hFFFF);
        send_op(OP_REMOVE, 5'd0, 4'd0, 12'd0, 16'd0);
        // fill to capacity, then full and duplicate rejections
        fill_unique(CAPACITY, 0);
        send_op(OP_INSERT, 5'd30, 4'd3, 12'd3000, 16'hFFFF);
        send_op(OP_INSERT, 5'd0, 4'd0, 12'd2000, 16'd1);
        send_op(OP_REPLACE, 5'd1, 4'd1, 12'd1, 16'd0);
        send_op(OP_REMOVE, 5'd0, 4'd0, 12'd0, 16'd0);
        send_op(OP_CLEAR, 5'd0, 4'd0, 12'd0, 16'd0);

        random_phase(160);
        send_idle = 63;
        recv_idle = 19;
        random_phase(160);
        send_idle = 0;
        recv_idle = 0;
        random_phase(160);
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0 && idle_cycles < 20000)
            @(posedge clk);
        repeat (1200) @(posedge clk);
        $display("covered %0d operations, %0d results, peak depth about %0d",
                 ops_sent, result_count, depth_peak);
        $display("including empty, full, duplicate and tie cases under varied stalls");
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
